>>> hdl/mtst_pkg.sv
// Package for the monitored task stall tracker.
// Holds the item types, the action codes and the table sizes.
// No dependencies; every other file imports it.
package mtst_pkg;

	// Table size and derived index width.
	localparam int SLOTS      = 9;
	localparam int SLOT_IDX_W = $clog2(SLOTS);

	// Field widths fixed by the interface.
	localparam int ID_W    = 22;
	localparam int PROG_W  = 32;
	localparam int TICK_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int ACT_W   = 3;

	localparam logic [TICK_W-1:0] THRESH_RESET = TICK_W'(10);
	localparam logic [TICK_W-1:0] TICK_MAX     = '1;

	// Command codes of an input item.
	typedef enum logic {
		CMD_WRITE   = 1'b0,
		CMD_OBSERVE = 1'b1
	} cmd_t;

	// Action codes of a result item.
	typedef enum logic [ACT_W-1:0] {
		ACT_WRITTEN = 3'd0,
		ACT_IGNORED = 3'd1,
		ACT_NOT_MON = 3'd2,
		ACT_RESET   = 3'd3,
		ACT_STALLED = 3'd4,
		ACT_FIRST   = 3'd5,
		ACT_STACK   = 3'd6,
		ACT_ZERO    = 3'd7
	} action_t;

	// Input item.
	typedef struct packed {
		logic              cmd;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   task_id;
		logic [PROG_W-1:0] progress_count;
		logic              frozen;
		logic              blocked;
		logic              user_task;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [SLOT_W-1:0] hit_slot;
		logic [TICK_W-1:0] stall_ticks;
	} rsp_t;

	// Per-slot state kept in the state memory.
	typedef struct packed {
		logic [PROG_W-1:0] last_progress;
		logic [TICK_W-1:0] tick_count;
		logic              reported;
	} entry_t;

endpackage

>>> hdl/mtst_state_ram.sv
// Per-slot state memory of the stall tracker: one write and one read port.
// Read data is registered; entries not yet written read as zero.
// Depends on mtst_pkg.
module mtst_state_ram
	import mtst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [SLOT_IDX_W-1:0] waddr,
	input  entry_t                wdata,
	input  logic                  re,
	input  logic [SLOT_IDX_W-1:0] raddr,
	output entry_t                rdata
);

	entry_t             mem_q [SLOTS];
	logic [SLOTS-1:0]   valid_q;
	entry_t             rd_raw_q;
	logic               rd_valid_q;

	// Storage array, written at one address a cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Valid bits stand in for the zero reset of the array.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_raw_q   <= mem_q[raddr];
			rd_valid_q <= valid_q[raddr];
		end
	end

	assign rdata = rd_valid_q ? rd_raw_q : '0;

endmodule

>>> hdl/monitored_task_stall_tracker_top.sv
// Top level of the monitored task stall tracker.
// An accepted item waits in stage one for its memory read; its result then
// goes to the output register when that register is empty or being emptied;
// a stalled receiver holds it back. No new item is taken before the last one
// completes: the read-modify-write of the state memory holds one item in flight.
// Reset clears the slot IDs, the memory valid bits, the threshold (to 10) and
// the handshake state; no clearing pass is needed.
module monitored_task_stall_tracker_top
	import mtst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [TICK_W-1:0]    cfg_wdata
);

	logic [TICK_W-1:0]     thresh_q;
	logic [ID_W-1:0]       slot_task_q [SLOTS];

	logic                  busy_q;
	req_t                  req_s1;
	logic                  in_range_s1;
	logic                  id_changed_s1;
	logic                  hit_s1;
	logic [SLOT_IDX_W-1:0] idx_s1;

	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic                  complete;
	logic                  in_range;
	logic [SLOT_IDX_W-1:0] wr_idx;
	logic                  found;
	logic [SLOT_IDX_W-1:0] found_idx;
	logic [SLOT_IDX_W-1:0] rd_idx;

	entry_t                rd_entry;
	entry_t                wr_entry;
	logic                  mem_we;
	rsp_t                  rsp_next;
	logic [TICK_W-1:0]     ticks_inc;

	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;
	assign complete  = busy_q && (!rsp_valid_q || rsp_ready);

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// Slot write decode and parallel ID match, lowest slot wins.
	always_comb begin
		in_range  = 32'(req.slot) < SLOTS;
		wr_idx    = SLOT_IDX_W'(req.slot);
		found     = 1'b0;
		found_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (req.task_id != '0 && slot_task_q[i] == req.task_id) begin
				found     = 1'b1;
				found_idx = SLOT_IDX_W'(i);
			end
		end
		rd_idx = (req.cmd == CMD_WRITE) ? wr_idx : found_idx;
	end

	// Stage one: hold the accepted item while the memory read returns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (complete) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1        <= req;
			in_range_s1   <= in_range;
			id_changed_s1 <= in_range && (slot_task_q[wr_idx] != req.task_id);
			hit_s1        <= found;
			idx_s1        <= rd_idx;
		end
	end

	mtst_state_ram u_state_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (idx_s1),
		.wdata  (wr_entry),
		.re     (accept),
		.raddr  (rd_idx),
		.rdata  (rd_entry)
	);

	// Modify step: work out the new slot state and the result item.
	always_comb begin
		ticks_inc = (rd_entry.tick_count < TICK_MAX) ?
			rd_entry.tick_count + TICK_W'(1) : rd_entry.tick_count;
		wr_entry  = rd_entry;
		mem_we    = 1'b0;
		rsp_next.action      = ACT_IGNORED;
		rsp_next.hit_slot    = '0;
		rsp_next.stall_ticks = '0;

		if (req_s1.cmd == CMD_WRITE) begin
			if (in_range_s1) begin
				rsp_next.action   = ACT_WRITTEN;
				rsp_next.hit_slot = SLOT_W'(idx_s1);
				if (id_changed_s1) begin
					wr_entry = '0;
					mem_we   = 1'b1;
				end else begin
					rsp_next.stall_ticks = rd_entry.tick_count;
				end
			end
		end else if (req_s1.blocked && req_s1.user_task) begin
			if (!hit_s1) begin
				rsp_next.action = ACT_NOT_MON;
			end else begin
				rsp_next.hit_slot = SLOT_W'(idx_s1);
				if (req_s1.frozen) begin
					rsp_next.action      = ACT_IGNORED;
					rsp_next.stall_ticks = rd_entry.tick_count;
				end else if (req_s1.progress_count == '0) begin
					wr_entry.last_progress = '0;
					mem_we                 = 1'b1;
					rsp_next.action        = ACT_ZERO;
					rsp_next.stall_ticks   = rd_entry.tick_count;
				end else if (req_s1.progress_count != rd_entry.last_progress) begin
					wr_entry.last_progress = req_s1.progress_count;
					wr_entry.tick_count    = '0;
					wr_entry.reported      = 1'b0;
					mem_we                 = 1'b1;
					rsp_next.action        = ACT_RESET;
				end else if (ticks_inc >= thresh_q) begin
					wr_entry.tick_count = '0;
					mem_we              = 1'b1;
					rsp_next.action     = ACT_STACK;
				end else begin
					wr_entry.tick_count  = ticks_inc;
					wr_entry.reported    = 1'b1;
					mem_we               = 1'b1;
					rsp_next.stall_ticks = ticks_inc;
					rsp_next.action      = rd_entry.reported ? ACT_STALLED : ACT_FIRST;
				end
			end
		end
		mem_we = mem_we && complete;
	end

	// Slot ID registers, updated when a slot write completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_task_q[i] <= '0;
			end
		end else if (complete && req_s1.cmd == CMD_WRITE && in_range_s1) begin
			slot_task_q[idx_s1] <= req_s1.task_id;
		end
	end

	// Output register parts the result from the next item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (complete) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
